FILE: rtl/rfrc_pkg.sv
package rfrc_pkg;

  localparam int FRAME_BYTES_DEF = 13;
  localparam int BYTE_W          = 8;
  localparam int ADDR_W          = 16;
  localparam int CFG_INDEX_W     = 3;
  localparam int CFG_DATA_W      = 16;

  // frame offsets
  localparam int OFS_LEN_HI   = 1;
  localparam int OFS_LEN_LO   = 2;
  localparam int OFS_API_ID   = 3;
  localparam int OFS_FRAME_ID = 4;
  localparam int OFS_ADDR_HI  = 5;
  localparam int OFS_ADDR_LO  = 6;
  localparam int OFS_OPTIONS  = 7;
  localparam int OFS_STATUS   = 8;
  localparam int OFS_JOY_ONE  = 9;
  localparam int OFS_JOY_TWO  = 10;
  localparam int OFS_DIGITAL  = 11;

  localparam logic [BYTE_W-1:0] SUM_GOOD = 8'hFF;

  // register reset values
  localparam logic [BYTE_W-1:0] RST_START_DELIM = 8'h7E;
  localparam logic [BYTE_W-1:0] RST_LEN_HI      = 8'h00;
  localparam logic [BYTE_W-1:0] RST_LEN_LO      = 8'h09;
  localparam logic [BYTE_W-1:0] RST_API_ID      = 8'h01;
  localparam logic [BYTE_W-1:0] RST_FRAME_ID    = 8'h00;
  localparam logic [ADDR_W-1:0] RST_OWN_ADDR    = 16'h2081;
  localparam logic [BYTE_W-1:0] RST_OPTIONS     = 8'h00;
  localparam logic [BYTE_W-1:0] RST_PAIR_CODE   = 8'h01;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_START_DELIM = 3'd0,
    CFG_LEN_HI      = 3'd1,
    CFG_LEN_LO      = 3'd2,
    CFG_API_ID      = 3'd3,
    CFG_FRAME_ID    = 3'd4,
    CFG_OWN_ADDR    = 3'd5,
    CFG_OPTIONS     = 3'd6,
    CFG_PAIR_CODE   = 3'd7
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_VALID    = 2'd0,
    ST_HEADER   = 2'd1,
    ST_ADDRESS  = 2'd2,
    ST_CHECKSUM = 2'd3
  } frame_status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] start_delimiter;
    logic [BYTE_W-1:0] length_high;
    logic [BYTE_W-1:0] length_low;
    logic [BYTE_W-1:0] api_identifier;
    logic [BYTE_W-1:0] frame_identifier;
    logic [ADDR_W-1:0] own_address;
    logic [BYTE_W-1:0] options_value;
    logic [BYTE_W-1:0] pairing_code;
  } cfg_t;

  typedef struct packed {
    frame_status_t     frame_status;
    logic [BYTE_W-1:0] status_value;
    logic [BYTE_W-1:0] joystick_one;
    logic [BYTE_W-1:0] joystick_two;
    logic [BYTE_W-1:0] digital_bits;
    logic [ADDR_W-1:0] source_address;
  } result_t;

  // handshake between the input register and the frame logic
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] rx_byte;
  } stage_t;

endpackage

FILE: rtl/rfrc_if.sv
interface rfrc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rfrc_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  frame_status;
  logic [7:0]  status_value;
  logic [7:0]  joystick_one;
  logic [7:0]  joystick_two;
  logic [7:0]  digital_bits;
  logic [15:0] source_address;

  modport source (output valid, output frame_status, output status_value,
                  output joystick_one, output joystick_two, output digital_bits,
                  output source_address, input ready);
  modport sink   (input valid, input frame_status, input status_value,
                  input joystick_one, input joystick_two, input digital_bits,
                  input source_address, output ready);
endinterface

FILE: rtl/rfrc_cfg_regs.sv
module rfrc_cfg_regs import rfrc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  logic [BYTE_W-1:0] data_byte;

  assign data_byte = cfg_data[BYTE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_delimiter  <= RST_START_DELIM;
      cfg.length_high      <= RST_LEN_HI;
      cfg.length_low       <= RST_LEN_LO;
      cfg.api_identifier   <= RST_API_ID;
      cfg.frame_identifier <= RST_FRAME_ID;
      cfg.own_address      <= RST_OWN_ADDR;
      cfg.options_value    <= RST_OPTIONS;
      cfg.pairing_code     <= RST_PAIR_CODE;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_START_DELIM: cfg.start_delimiter  <= data_byte;
        CFG_LEN_HI:      cfg.length_high      <= data_byte;
        CFG_LEN_LO:      cfg.length_low       <= data_byte;
        CFG_API_ID:      cfg.api_identifier   <= data_byte;
        CFG_FRAME_ID:    cfg.frame_identifier <= data_byte;
        CFG_OWN_ADDR:    cfg.own_address      <= cfg_data[ADDR_W-1:0];
        CFG_OPTIONS:     cfg.options_value    <= data_byte;
        CFG_PAIR_CODE:   cfg.pairing_code     <= data_byte;
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/rfrc_in_stage.sv
module rfrc_in_stage import rfrc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  rfrc_byte_if.sink   rx,
  input  logic        advance,
  output stage_t      stage
);

  // the held byte moves on whenever the result side can take a result
  assign rx.ready = !stage.valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (rx.ready) begin
      stage.valid <= rx.valid;
    end
    if (rx.ready && rx.valid) begin
      stage.rx_byte <= rx.rx_byte;
    end
  end

endmodule

FILE: rtl/rfrc_parser.sv
module rfrc_parser import rfrc_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  stage_t  stage,
  input  logic    advance,
  output logic    emit,
  output result_t result
);

  localparam int POS_W = $clog2(FRAME_BYTES);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

  logic [POS_W-1:0]  frame_position, frame_position_next;
  logic              header_good, header_good_next;
  logic              address_good, address_good_next;
  logic [BYTE_W-1:0] running_sum, running_sum_next;
  logic [BYTE_W-1:0] address_high_hold;
  logic [BYTE_W-1:0] payload_hold [4];
  logic [ADDR_W-1:0] paired_address, paired_address_next;

  logic              fire;
  logic              is_start;
  logic              in_frame;
  logic [BYTE_W-1:0] b;
  frame_status_t     status;

  assign fire     = stage.valid && advance;
  assign b        = stage.rx_byte;
  assign is_start = (b == cfg.start_delimiter);
  assign in_frame = fire && !is_start && (frame_position != '0);

  always_comb begin
    frame_position_next = frame_position;
    header_good_next    = header_good;
    address_good_next   = address_good;
    running_sum_next    = running_sum;
    emit                = 1'b0;
    if (fire && is_start) begin
      frame_position_next = POS_W'(1);
      header_good_next    = 1'b1;
      address_good_next   = 1'b1;
      running_sum_next    = '0;
    end else if (in_frame) begin
      // checksum covers the api id through the last byte
      if (frame_position >= POS_W'(OFS_API_ID)) begin
        running_sum_next = running_sum + b;
      end
      case (frame_position)
        POS_W'(OFS_LEN_HI):   if (b != cfg.length_high)      header_good_next = 1'b0;
        POS_W'(OFS_LEN_LO):   if (b != cfg.length_low)       header_good_next = 1'b0;
        POS_W'(OFS_API_ID):   if (b != cfg.api_identifier)   header_good_next = 1'b0;
        POS_W'(OFS_FRAME_ID): if (b != cfg.frame_identifier) header_good_next = 1'b0;
        POS_W'(OFS_ADDR_LO):
          if ({address_high_hold, b} != cfg.own_address) address_good_next = 1'b0;
        POS_W'(OFS_OPTIONS):  if (b != cfg.options_value)    header_good_next = 1'b0;
        default: ;
      endcase
      if (frame_position < LAST_POS) begin
        frame_position_next = frame_position + POS_W'(1);
      end else begin
        frame_position_next = '0;
        emit                = 1'b1;
      end
    end
  end

  // priority: header, then address, then checksum
  always_comb begin
    if (!header_good_next) begin
      status = ST_HEADER;
    end else if (!address_good_next) begin
      status = ST_ADDRESS;
    end else if (running_sum_next != SUM_GOOD) begin
      status = ST_CHECKSUM;
    end else begin
      status = ST_VALID;
    end
  end

  always_comb begin
    paired_address_next = paired_address;
    if (emit && status == ST_VALID && payload_hold[0] == cfg.pairing_code) begin
      paired_address_next = {payload_hold[1], payload_hold[2]};
    end
  end

  assign result.frame_status   = status;
  assign result.status_value   = payload_hold[0];
  assign result.joystick_one   = payload_hold[1];
  assign result.joystick_two   = payload_hold[2];
  assign result.digital_bits   = payload_hold[3];
  assign result.source_address = paired_address_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position    <= '0;
      header_good       <= 1'b1;
      address_good      <= 1'b1;
      running_sum       <= '0;
      address_high_hold <= '0;
      paired_address    <= '0;
    end else begin
      frame_position <= frame_position_next;
      header_good    <= header_good_next;
      address_good   <= address_good_next;
      running_sum    <= running_sum_next;
      paired_address <= paired_address_next;
      if (in_frame && frame_position == POS_W'(OFS_ADDR_HI)) begin
        address_high_hold <= b;
      end
    end
  end

  // command bytes at offsets eight to eleven
  always_ff @(posedge clk) begin
    if (in_frame && frame_position >= POS_W'(OFS_STATUS)
        && frame_position <= POS_W'(OFS_DIGITAL)) begin
      payload_hold[frame_position[1:0]] <= b;
    end
  end

`ifndef NO_ASSERTIONS
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    frame_position <= LAST_POS)
    else $error("frame position past last byte");

  a_emit_closes: assert property (@(posedge clk) disable iff (rst)
    emit |=> frame_position == '0)
    else $error("frame not closed after result");

  a_start_opens: assert property (@(posedge clk) disable iff (rst)
    fire && is_start |=> frame_position == POS_W'(1) && running_sum == '0
                         && header_good && address_good)
    else $error("start byte did not open a clean frame");

  a_pair_only_valid: assert property (@(posedge clk) disable iff (rst)
    paired_address_next != paired_address |-> emit && status == ST_VALID)
    else $error("paired address changed without a valid frame");
`endif

endmodule

FILE: rtl/rfrc_out_reg.sv
module rfrc_out_reg import rfrc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          emit,
  input  result_t       result,
  output logic          advance,
  rfrc_result_if.source res
);

  result_t held;

  // the frame logic may run whenever this register is free or being emptied
  assign advance = !res.valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (advance) begin
      res.valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      held <= result;
    end
  end

  assign res.frame_status   = held.frame_status;
  assign res.status_value   = held.status_value;
  assign res.joystick_one   = held.joystick_one;
  assign res.joystick_two   = held.joystick_two;
  assign res.digital_bits   = held.digital_bits;
  assign res.source_address = held.source_address;

endmodule

FILE: rtl/radio_frame_receiver_checker.sv
// channel  | dir | handshake     | payload
// rx       | in  | valid / ready | rx_byte
// result   | out | valid / ready | frame_status, status_value, joystick_one,
//          |     |               | joystick_two, digital_bits, source_address
// cfg      | in  | cfg_we        | cfg_index, cfg_data
//
// one byte is taken every cycle unless a stalled result holds the input
// register; a frame's result is registered after the input register and frame logic
// rate is set by the single frame pass between the two registers
// rst is synchronous: frame tracking restarts, config returns to defaults
// a stalled result holds the result register; the input register still takes
// a byte as long as it is empty
module radio_frame_receiver_checker import rfrc_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  rfrc_byte_if.sink              rx,
  rfrc_result_if.source          result,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t    cfg;
  stage_t  stage;
  logic    advance;
  logic    emit;
  result_t frame_result;

  // configuration registers; the user writes them only while the block is idle, the block does not enforce it
  rfrc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // input register in front of the frame logic
  rfrc_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx),
    .advance (advance),
    .stage   (stage)
  );

  // frame position, header/address checks, checksum, pairing address
  rfrc_parser #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .stage   (stage),
    .advance (advance),
    .emit    (emit),
    .result  (frame_result)
  );

  // result register; drives the outgoing item
  rfrc_out_reg u_out (
    .clk     (clk),
    .rst     (rst),
    .emit    (emit),
    .result  (frame_result),
    .advance (advance),
    .res     (result)
  );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import rfrc_pkg::*;

  localparam int FRAME_LEN   = FRAME_BYTES_DEF;
  localparam int IDLE_PCT    = 29;
  localparam int SETTLE      = 8;     // covers the two-register path with margin
  localparam int STALL_LIMIT = 2000;  // cycles with no item moving on either side
  localparam int ITEM_TARGET = 1850;
  localparam int PHASE_ITEMS = 260;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  rfrc_byte_if   rx_if ();
  rfrc_result_if res_if ();

  radio_frame_receiver_checker DUT (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx_if),
    .result    (res_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // frame tracker: own copy of the registers and of the receive state
  // ---------------------------------------------------------------------------
  cfg_t              live_cfg;
  logic [3:0]        frame_pos;
  logic              hdr_ok;
  logic              addr_ok;
  logic [7:0]        csum;
  logic [7:0]        addr_hi;
  logic [7:0]        payload [4];
  logic [ADDR_W-1:0] paired_addr;

  result_t    frame_reports [$];  // reports owed by the block, oldest first
  logic [7:0] byte_queue [$];     // bytes waiting for the driver

  int unsigned bytes_pushed = 0;
  int unsigned bytes_taken  = 0;
  int unsigned reports_seen = 0;
  int unsigned pairings     = 0;
  int unsigned settings_run = 1;
  int unsigned error_count  = 0;
  int unsigned status_seen [4] = '{0, 0, 0, 0};
  int unsigned stall_cycles = 0;
  bit          no_gaps      = 1'b0;
  bit          byte_taken   = 1'b0;
  bit          report_taken = 1'b0;
  result_t     oldest_report;

  // register file as it stands after reset
  initial begin
    live_cfg.start_delimiter  = RST_START_DELIM;
    live_cfg.length_high      = RST_LEN_HI;
    live_cfg.length_low       = RST_LEN_LO;
    live_cfg.api_identifier   = RST_API_ID;
    live_cfg.frame_identifier = RST_FRAME_ID;
    live_cfg.own_address      = RST_OWN_ADDR;
    live_cfg.options_value    = RST_OPTIONS;
    live_cfg.pairing_code     = RST_PAIR_CODE;
    frame_pos   = '0;
    hdr_ok      = 1'b1;
    addr_ok     = 1'b1;
    csum        = '0;
    addr_hi     = '0;
    payload     = '{8'h00, 8'h00, 8'h00, 8'h00};
    paired_addr = '0;
  end

  function automatic void apply_cfg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_START_DELIM: live_cfg.start_delimiter  = data[7:0];
      CFG_LEN_HI:      live_cfg.length_high      = data[7:0];
      CFG_LEN_LO:      live_cfg.length_low       = data[7:0];
      CFG_API_ID:      live_cfg.api_identifier   = data[7:0];
      CFG_FRAME_ID:    live_cfg.frame_identifier = data[7:0];
      CFG_OWN_ADDR:    live_cfg.own_address      = data;
      CFG_OPTIONS:     live_cfg.options_value    = data[7:0];
      CFG_PAIR_CODE:   live_cfg.pairing_code     = data[7:0];
      default: ;
    endcase
  endfunction

  // one received byte through the frame logic; a report is owed on the last byte
  function automatic void track_frame_byte(logic [7:0] b);
    logic [3:0] pos;
    result_t    rep;
    pos = frame_pos;
    // the start byte wins over everything, even in the checksum slot
    if (b == live_cfg.start_delimiter) begin
      frame_pos = 4'd1;
      hdr_ok    = 1'b1;
      addr_ok   = 1'b1;
      csum      = '0;
      return;
    end
    // no open frame: byte is dropped
    if (pos == 0) return;
    if (pos >= OFS_API_ID) csum = csum + b;
    case (pos)
      OFS_LEN_HI:   if (b != live_cfg.length_high) hdr_ok = 1'b0;
      OFS_LEN_LO:   if (b != live_cfg.length_low) hdr_ok = 1'b0;
      OFS_API_ID:   if (b != live_cfg.api_identifier) hdr_ok = 1'b0;
      OFS_FRAME_ID: if (b != live_cfg.frame_identifier) hdr_ok = 1'b0;
      OFS_ADDR_HI:  addr_hi = b;
      OFS_ADDR_LO:  if ({addr_hi, b} != live_cfg.own_address) addr_ok = 1'b0;
      OFS_OPTIONS:  if (b != live_cfg.options_value) hdr_ok = 1'b0;
      OFS_STATUS, OFS_JOY_ONE, OFS_JOY_TWO, OFS_DIGITAL: payload[pos - OFS_STATUS] = b;
      default: ;  // extra bytes only feed the checksum
    endcase
    if (pos < FRAME_LEN - 1) begin
      frame_pos = pos + 4'd1;
      return;
    end
    frame_pos = '0;
    // header beats address beats checksum
    if (!hdr_ok) rep.frame_status = ST_HEADER;
    else if (!addr_ok) rep.frame_status = ST_ADDRESS;
    else if (csum != SUM_GOOD) rep.frame_status = ST_CHECKSUM;
    else rep.frame_status = ST_VALID;
    if (rep.frame_status == ST_VALID && payload[0] == live_cfg.pairing_code) begin
      paired_addr = {payload[1], payload[2]};
      pairings++;
    end
    rep.status_value   = payload[0];
    rep.joystick_one   = payload[1];
    rep.joystick_two   = payload[2];
    rep.digital_bits   = payload[3];
    rep.source_address = paired_addr;
    frame_reports.push_back(rep);
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void push_byte(logic [7:0] b);
    byte_queue.push_back(b);
    bytes_pushed++;
  endfunction

  // any byte except the start byte
  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == live_cfg.start_delimiter);
    return b;
  endfunction

  // a byte differing from x and from the start byte
  function automatic logic [7:0] other_byte(logic [7:0] x);
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == x || b == live_cfg.start_delimiter);
    return b;
  endfunction

  function automatic bit take_break();
    return !no_gaps && ($urandom_range(99) < IDLE_PCT);
  endfunction

  // builds one frame for the current registers, optionally broken, and queues
  // its first keep bytes
  function automatic void push_frame(logic [7:0] st, logic [7:0] j1, logic [7:0] j2,
                                     logic [7:0] dig, bit bad_hdr, bit bad_addr,
                                     bit bad_sum, int keep);
    logic [7:0] f [FRAME_LEN];
    logic [7:0] sum;
    int         spot;
    f[0]            = live_cfg.start_delimiter;
    f[OFS_LEN_HI]   = live_cfg.length_high;
    f[OFS_LEN_LO]   = live_cfg.length_low;
    f[OFS_API_ID]   = live_cfg.api_identifier;
    f[OFS_FRAME_ID] = live_cfg.frame_identifier;
    f[OFS_ADDR_HI]  = live_cfg.own_address[15:8];
    f[OFS_ADDR_LO]  = live_cfg.own_address[7:0];
    f[OFS_OPTIONS]  = live_cfg.options_value;
    f[OFS_STATUS]   = st;
    f[OFS_JOY_ONE]  = j1;
    f[OFS_JOY_TWO]  = j2;
    f[OFS_DIGITAL]  = dig;
    for (int i = OFS_DIGITAL + 1; i < FRAME_LEN - 1; i++) f[i] = pick_byte();
    if (bad_hdr) begin
      case ($urandom_range(4))
        0:       spot = OFS_LEN_HI;
        1:       spot = OFS_LEN_LO;
        2:       spot = OFS_API_ID;
        3:       spot = OFS_FRAME_ID;
        default: spot = OFS_OPTIONS;
      endcase
      f[spot] = other_byte(f[spot]);
    end
    if (bad_addr) begin
      spot    = $urandom_range(1) ? OFS_ADDR_HI : OFS_ADDR_LO;
      f[spot] = other_byte(f[spot]);
    end
    // checksum must not look like a start byte, so nudge the buttons byte
    do begin
      sum = '0;
      for (int i = OFS_API_ID; i < FRAME_LEN - 1; i++) sum = sum + f[i];
      f[FRAME_LEN-1] = SUM_GOOD - sum;
      if (bad_sum) f[FRAME_LEN-1] = f[FRAME_LEN-1] + 8'($urandom_range(1, 255));
      if (f[FRAME_LEN-1] == live_cfg.start_delimiter) f[OFS_DIGITAL] = pick_byte();
    end while (f[FRAME_LEN-1] == live_cfg.start_delimiter);
    for (int i = 0; i < keep; i++) push_byte(f[i]);
  endfunction

  // register write, one per falling edge; tracker copy follows at once since
  // nothing is in flight while registers change
  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    apply_cfg(idx, data);
    @(negedge clk);
  endtask

  // 8-bit registers get junk in the upper byte, which must be ignored
  function automatic logic [CFG_DATA_W-1:0] with_junk(logic [7:0] v);
    return {8'($urandom_range(255)), v};
  endfunction

  // extremes first, then random settings that keep the start byte unique
  task automatic load_settings(int phase);
    logic [7:0] d;
    logic [7:0] fill;
    bit         pick;
    case (phase)
      1:       begin d = 8'hFF; fill = 8'h00; pick = 1'b0; end
      2:       begin d = 8'h00; fill = 8'hFF; pick = 1'b0; end
      default: begin d = 8'($urandom_range(255)); fill = 8'h00; pick = 1'b1; end
    endcase
    write_reg(CFG_START_DELIM, with_junk(d));
    write_reg(CFG_LEN_HI,    with_junk(pick ? pick_byte() : fill));
    write_reg(CFG_LEN_LO,    with_junk(pick ? pick_byte() : fill));
    write_reg(CFG_API_ID,    with_junk(pick ? pick_byte() : fill));
    write_reg(CFG_FRAME_ID,  with_junk(pick ? pick_byte() : fill));
    write_reg(CFG_OWN_ADDR,  pick ? {pick_byte(), pick_byte()} : {fill, fill});
    write_reg(CFG_OPTIONS,   with_junk(pick ? pick_byte() : fill));
    write_reg(CFG_PAIR_CODE, with_junk(pick ? pick_byte() : fill));
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  // every queued byte taken, every owed report seen, pipeline drained
  task automatic wait_idle();
    while (bytes_taken != bytes_pushed || frame_reports.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // byte driver: holds valid until the item is taken, gaps at random
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      rx_if.valid <= 1'b0;
    end else if (!rx_if.valid || byte_taken) begin
      if (byte_queue.size() != 0 && !take_break()) begin
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= byte_queue.pop_front();
      end else begin
        rx_if.valid <= 1'b0;
      end
    end
  end

  // report side back-pressure
  always @(negedge clk) begin
    res_if.ready <= !rst && !take_break();
  end

  // ---------------------------------------------------------------------------
  // monitor: compare reports, then track accepted bytes, then watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    byte_taken   = 1'b0;
    report_taken = 1'b0;
    if (!rst) begin
      if (res_if.valid && res_if.ready) begin
        report_taken = 1'b1;
        if (frame_reports.size() == 0) begin
          $error("frame report with none owed: status %0d", res_if.frame_status);
          error_count++;
        end else begin
          oldest_report = frame_reports.pop_front();
          reports_seen++;
          status_seen[int'(oldest_report.frame_status)]++;
          if (res_if.frame_status !== oldest_report.frame_status) begin
            $error("frame_status: expected %0d, got %0d",
                   oldest_report.frame_status, res_if.frame_status);
            error_count++;
          end
          if (res_if.status_value !== oldest_report.status_value) begin
            $error("status_value: expected %0h, got %0h",
                   oldest_report.status_value, res_if.status_value);
            error_count++;
          end
          if (res_if.joystick_one !== oldest_report.joystick_one) begin
            $error("joystick_one: expected %0h, got %0h",
                   oldest_report.joystick_one, res_if.joystick_one);
            error_count++;
          end
          if (res_if.joystick_two !== oldest_report.joystick_two) begin
            $error("joystick_two: expected %0h, got %0h",
                   oldest_report.joystick_two, res_if.joystick_two);
            error_count++;
          end
          if (res_if.digital_bits !== oldest_report.digital_bits) begin
            $error("digital_bits: expected %0h, got %0h",
                   oldest_report.digital_bits, res_if.digital_bits);
            error_count++;
          end
          if (res_if.source_address !== oldest_report.source_address) begin
            $error("source_address: expected %0h, got %0h",
                   oldest_report.source_address, res_if.source_address);
            error_count++;
          end
        end
      end
      if (rx_if.valid && rx_if.ready) begin
        byte_taken = 1'b1;
        bytes_taken++;
        track_frame_byte(rx_if.rx_byte);
      end
      // watchdog: nothing moving for too long means the block is stuck
      if (byte_taken || report_taken) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles, %0d reports still owed",
                 stall_cycles, frame_reports.size());
        $display("tb: errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned phase_end;
    int          phase;
    int          roll;
    logic [7:0]  st;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    res_if.ready  = 1'b0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // directed, reset settings: stray byte before any start, then a clean
    // pairing frame with extreme payload, then a frame cut off right before
    // its checksum by the next start byte
    push_byte(8'hFF);
    push_frame(RST_PAIR_CODE, 8'hFF, 8'h00, 8'hFF, 1'b0, 1'b0, 1'b0, FRAME_LEN);
    push_frame(8'h00, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b0, FRAME_LEN - 1);

    phase = 0;
    while (bytes_pushed < ITEM_TARGET) begin
      if (phase != 0) begin
        wait_idle();
        load_settings(phase);
      end
      // one phase runs with no gaps on either side
      no_gaps   = (phase == 3);
      phase_end = bytes_pushed + PHASE_ITEMS;
      while (bytes_pushed < phase_end) begin
        roll = $urandom_range(99);
        st   = $urandom_range(1) ? live_cfg.pairing_code : pick_byte();
        if (roll < 55)
          push_frame(st, pick_byte(), pick_byte(), pick_byte(), 1'b0, 1'b0, 1'b0,
                     FRAME_LEN);
        else if (roll < 65)
          push_frame(st, pick_byte(), pick_byte(), pick_byte(), 1'b1, 1'b0, 1'b0,
                     FRAME_LEN);
        else if (roll < 73)
          push_frame(st, pick_byte(), pick_byte(), pick_byte(), 1'b0, 1'b1, 1'b0,
                     FRAME_LEN);
        else if (roll < 81)
          push_frame(st, pick_byte(), pick_byte(), pick_byte(), 1'b0, 1'b0, 1'b1,
                     FRAME_LEN);
        else if (roll < 89)
          // several faults at once to exercise the reporting priority
          push_frame(st, pick_byte(), pick_byte(), pick_byte(), 1'($urandom_range(1)),
                     1'b1, 1'($urandom_range(1)), FRAME_LEN);
        else
          // cut short; the next start byte abandons it
          push_frame(st, pick_byte(), pick_byte(), pick_byte(), 1'b0, 1'b0, 1'b0,
                     $urandom_range(1, FRAME_LEN - 1));
        // stray bytes of any value, start byte included
        if ($urandom_range(99) < 10)
          repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(255)));
      end
      phase++;
    end

    wait_idle();
    $display("summary: %0d bytes over %0d register settings, %0d frame reports checked",
             bytes_taken, settings_run, reports_seen);
    $display("summary: valid %0d, header %0d, address %0d, checksum %0d, pairings %0d",
             status_seen[ST_VALID], status_seen[ST_HEADER], status_seen[ST_ADDRESS],
             status_seen[ST_CHECKSUM], pairings);
    if (error_count == 0 && frame_reports.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
